FILE: hw/rtl/tdpe_pkg.sv
// Shared types, constants and the sequencer program of the triaxial DPCM packet encoder.
package tdpe_pkg;

	localparam int SAMPLES_PER_PACKET = 12;
	localparam int CNT_W  = $clog2(SAMPLES_PER_PACKET + 1);
	localparam int ADDR_W = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;
	localparam int PC_W   = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [7:0]  PKT_FLAGS     = 8'h01;
	localparam logic [7:0]  QUANT_STEP    = 8'd128;
	localparam logic signed [9:0] DELTA_LIMIT = 10'sd127;
	localparam logic [16:0] ROUND_POS     = 17'd64;
	localparam logic [16:0] ROUND_NEG     = 17'd63;
	localparam logic [15:0] MEDIUM_RST    = 16'd200;
	localparam logic [15:0] HIGH_RST      = 16'd800;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_X = 3'd0,
		CFG_OFFSET_Y = 3'd1,
		CFG_OFFSET_Z = 3'd2,
		CFG_MEDIUM   = 3'd3,
		CFG_HIGH     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic               opcode;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       last_byte;
		logic [1:0] alarm_level;
	} packet_t;

	// one buffered sample, offsets already removed
	typedef struct packed {
		logic [15:0] z;
		logic [15:0] y;
		logic [15:0] x;
	} stored_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	typedef enum logic [2:0] {
		BS_SEQ_LO = 3'd0,
		BS_SEQ_HI = 3'd1,
		BS_FLAGS  = 3'd2,
		BS_COUNT  = 3'd3,
		BS_SCALE  = 3'd4,
		BS_ABS_LO = 3'd5,
		BS_ABS_HI = 3'd6,
		BS_DELTA  = 3'd7
	} byte_sel_t;

	typedef enum logic [1:0] {
		RD_NONE  = 2'd0,
		RD_FIRST = 2'd1,
		RD_NEXT  = 2'd2
	} rd_t;

	typedef enum logic [1:0] {
		J_SEQ     = 2'd0,
		J_IF_MORE = 2'd1,
		J_IF_DONE = 2'd2,
		J_END     = 2'd3
	} jmp_t;

	typedef struct packed {
		byte_sel_t       src;
		logic            ld;
		axis_t           ax;
		logic            delta;
		logic            pk;
		logic            load_prev;
		rd_t             rd;
		jmp_t            jmp;
		logic [PC_W-1:0] tgt;
	} uop_t;

	localparam logic [PC_W-1:0] PC_LOOP  = 5'd11;
	localparam logic [PC_W-1:0] PC_DRAIN = 5'd14;

	function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{src: BS_FLAGS, ld: 1'b0, ax: AX_X, delta: 1'b0, pk: 1'b0,
			load_prev: 1'b0, rd: RD_NONE, jmp: J_SEQ, tgt: '0};
		case (pc)
			5'd0: begin
				u.src = BS_SEQ_LO; u.ld = 1'b1; u.rd = RD_FIRST;
			end
			5'd1: begin
				u.src = BS_SEQ_HI; u.ld = 1'b1; u.load_prev = 1'b1;
			end
			5'd2: begin
				u.src = BS_FLAGS; u.ld = 1'b1;
			end
			5'd3: begin
				u.src = BS_COUNT; u.ld = 1'b1;
			end
			5'd4: begin
				u.src = BS_SCALE; u.ld = 1'b1;
			end
			5'd5: begin
				u.src = BS_ABS_LO; u.ld = 1'b1; u.ax = AX_X; u.pk = 1'b1;
			end
			5'd6: begin
				u.src = BS_ABS_HI; u.ld = 1'b1; u.ax = AX_X;
			end
			5'd7: begin
				u.src = BS_ABS_LO; u.ld = 1'b1; u.ax = AX_Y; u.pk = 1'b1;
			end
			5'd8: begin
				u.src = BS_ABS_HI; u.ld = 1'b1; u.ax = AX_Y;
			end
			5'd9: begin
				u.src = BS_ABS_LO; u.ld = 1'b1; u.ax = AX_Z; u.pk = 1'b1;
			end
			5'd10: begin
				u.src = BS_ABS_HI; u.ld = 1'b1; u.ax = AX_Z;
				u.rd = RD_NEXT; u.jmp = J_IF_DONE; u.tgt = PC_DRAIN;
			end
			5'd11: begin
				u.src = BS_DELTA; u.ld = 1'b1; u.ax = AX_X; u.delta = 1'b1;
			end
			5'd12: begin
				u.src = BS_DELTA; u.ld = 1'b1; u.ax = AX_Y; u.delta = 1'b1;
			end
			5'd13: begin
				u.src = BS_DELTA; u.ld = 1'b1; u.ax = AX_Z; u.delta = 1'b1;
				u.rd = RD_NEXT; u.jmp = J_IF_MORE; u.tgt = PC_LOOP;
			end
			5'd14: begin
				u.jmp = J_SEQ;
			end
			5'd15: begin
				u.jmp = J_SEQ;
			end
			default: begin
				u.jmp = J_END;
			end
		endcase
		return u;
	endfunction

endpackage

FILE: hw/rtl/tdpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdpe_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 12
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/triaxial_dpcm_packet_encoder.sv
// Top level of the triaxial DPCM packet encoder: sample buffer, microcoded packet sequencer.
// A sample beat that does not complete a packet leaves the block idle; the next may follow at once.
// A packet of n samples (11 + 3*(n-1) bytes) keeps the sequencer busy until its last byte is pushed;
// its first byte goes through the hold and output registers, then one byte a cycle without stall.
// The one-byte hold register in front of the output and the three-step peak pipeline set the tail.
// Reset restores offsets to 0 and thresholds to 200 / 800, clears count and sequence number;
// the sample buffer is not cleared, since every entry is written before it is read.
module triaxial_dpcm_packet_encoder (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    sample_valid,
	output logic                                    sample_stall,
	input  tdpe_pkg::sample_t                       sample,
	output logic                                    packet_valid,
	input  logic                                    packet_stall,
	output tdpe_pkg::packet_t                       packet,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [tdpe_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [15:0]                             cfg_data
);

	import tdpe_pkg::*;

	// configuration registers
	logic [15:0] off_x_q, off_y_q, off_z_q, med_q, high_q;

	// buffer bookkeeping
	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       seq_q;
	logic              busy_q;
	logic [PC_W-1:0]   pc_q;
	logic [ADDR_W-1:0] idx_q;

	// datapath
	logic [15:0] prev_q [3];
	logic [15:0] peak_q;
	logic [15:0] pk_src_q;
	logic        pk_v_q;
	logic [7:0]  hold_q;
	logic        hold_v_q;
	logic [7:0]  q_s1;
	axis_t       ax_s1;
	logic        upd_s1;

	logic        out_v_q;
	packet_t     out_q;

	uop_t              uop;
	logic              sample_acc;
	logic              out_free;
	logic              want_push;
	logic              adv;
	logic              more;
	logic [CNT_W-1:0]  cnt_inc;
	logic              start;
	stored_t           wr_data;
	stored_t           rd_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] idx_nxt;
	logic [15:0]       cur_v;
	logic [15:0]       prev_v;
	logic [15:0]       diff;
	logic [16:0]       rnd;
	logic signed [9:0] qw;
	logic [7:0]        q8;
	logic [15:0]       recon;
	logic [15:0]       pk_mag;
	logic [7:0]        byte_nxt;
	logic [1:0]        level;

	assign cfg_ready    = 1'b1;
	assign sample_stall = busy_q;
	assign sample_acc   = sample_valid && !busy_q;

	assign packet_valid = out_v_q;
	assign packet       = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			med_q   <= MEDIUM_RST;
			high_q  <= HIGH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OFFSET_X: off_x_q <= cfg_data;
				CFG_OFFSET_Y: off_y_q <= cfg_data;
				CFG_OFFSET_Z: off_z_q <= cfg_data;
				CFG_MEDIUM:   med_q   <= cfg_data;
				CFG_HIGH:     high_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Input side: store offset-corrected samples, kick the sequencer when the
	// buffer fills or a flush arrives with samples held.
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign wr_data = '{z: sample.accel_z - off_z_q,
		y: sample.accel_y - off_y_q,
		x: sample.accel_x - off_x_q};
	always_comb begin
		start = 1'b0;
		if (sample_acc) begin
			if (sample.opcode == OP_SAMPLE) begin
				start = (cnt_inc == CNT_W'(SAMPLES_PER_PACKET));
			end else begin
				start = (cnt_q != '0);
			end
		end
	end

	tdpe_ram #(
		.WIDTH($bits(stored_t)),
		.DEPTH(SAMPLES_PER_PACKET)
	) u_store (
		.clk  (clk),
		.we   (sample_acc && (sample.opcode == OP_SAMPLE)),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Sequencer: fetch the control word, advance unless a beat must leave and
	// the output register is full and stalled.
	assign uop       = uop_at(pc_q);
	assign out_free  = !out_v_q || !packet_stall;
	assign want_push = (uop.ld && hold_v_q) || (uop.jmp == J_END);
	assign adv       = busy_q && (!want_push || out_free);
	assign more      = (CNT_W'(idx_q) + CNT_W'(1)) < cnt_q;
	assign idx_nxt   = idx_q + ADDR_W'(1);
	assign rd_en     = adv && ((uop.rd == RD_FIRST) || ((uop.rd == RD_NEXT) && more));
	assign rd_addr   = (uop.rd == RD_FIRST) ? '0 : idx_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			seq_q    <= '0;
			busy_q   <= 1'b0;
			pc_q     <= '0;
			idx_q    <= '0;
			hold_v_q <= 1'b0;
		end else if (!busy_q) begin
			if (sample_acc && (sample.opcode == OP_SAMPLE)) begin
				cnt_q <= cnt_inc;
			end
			if (start) begin
				busy_q   <= 1'b1;
				pc_q     <= '0;
				hold_v_q <= 1'b0;
			end
		end else if (adv) begin
			if (uop.ld) begin
				hold_v_q <= 1'b1;
			end
			if (uop.rd == RD_FIRST) begin
				idx_q <= '0;
			end else if ((uop.rd == RD_NEXT) && more) begin
				idx_q <= idx_nxt;
			end
			case (uop.jmp)
				J_SEQ:     pc_q <= pc_q + PC_W'(1);
				J_IF_MORE: pc_q <= more ? uop.tgt : pc_q + PC_W'(1);
				J_IF_DONE: pc_q <= more ? pc_q + PC_W'(1) : uop.tgt;
				J_END: begin
					// packet done: drop the held samples, bump the sequence number
					busy_q   <= 1'b0;
					hold_v_q <= 1'b0;
					cnt_q    <= '0;
					seq_q    <= seq_q + 16'd1;
				end
				default: pc_q <= pc_q;
			endcase
		end
	end

	// Delta quantizer: round half away from zero by 128, saturate to +-127.
	always_comb begin
		case (uop.ax)
			AX_X:    cur_v = rd_data.x;
			AX_Y:    cur_v = rd_data.y;
			AX_Z:    cur_v = rd_data.z;
			default: cur_v = rd_data.x;
		endcase
		case (uop.ax)
			AX_X:    prev_v = prev_q[0];
			AX_Y:    prev_v = prev_q[1];
			AX_Z:    prev_v = prev_q[2];
			default: prev_v = prev_q[0];
		endcase
	end

	assign diff = cur_v - prev_v;
	assign rnd  = {diff[15], diff} + (diff[15] ? ROUND_NEG : ROUND_POS);
	assign qw   = $signed(rnd[16:7]);
	always_comb begin
		if (qw > DELTA_LIMIT) begin
			q8 = DELTA_LIMIT[7:0];
		end else if (qw < -DELTA_LIMIT) begin
			q8 = 8'(-DELTA_LIMIT);
		end else begin
			q8 = qw[7:0];
		end
	end

	always_comb begin
		case (uop.src)
			BS_SEQ_LO: byte_nxt = seq_q[7:0];
			BS_SEQ_HI: byte_nxt = seq_q[15:8];
			BS_FLAGS:  byte_nxt = PKT_FLAGS;
			BS_COUNT:  byte_nxt = 8'(cnt_q);
			BS_SCALE:  byte_nxt = QUANT_STEP;
			BS_ABS_LO: byte_nxt = prev_v[7:0];
			BS_ABS_HI: byte_nxt = prev_v[15:8];
			BS_DELTA:  byte_nxt = q8;
			default:   byte_nxt = PKT_FLAGS;
		endcase
	end

	// Reconstruction in the cycle after the quantizer; each axis is revisited
	// only after the steps of the other two axes, so the update is always in time.
	assign recon  = prev_q[ax_s1] + {q_s1[7], q_s1, 7'b0};
	assign pk_mag = pk_src_q[15] ? (~pk_src_q + 16'd1) : pk_src_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= 1'b0;
			pk_v_q <= 1'b0;
		end else begin
			upd_s1 <= adv && uop.delta;
			pk_v_q <= upd_s1 || (adv && uop.pk);
		end
	end

	always_ff @(posedge clk) begin
		q_s1  <= q8;
		ax_s1 <= uop.ax;
		if (adv && uop.ld) begin
			hold_q <= byte_nxt;
		end
		if (adv && uop.load_prev) begin
			prev_q[0] <= rd_data.x;
			prev_q[1] <= rd_data.y;
			prev_q[2] <= rd_data.z;
			peak_q    <= '0;
		end else begin
			if (upd_s1) begin
				prev_q[ax_s1] <= recon;
			end
			if (pk_v_q && (pk_mag > peak_q)) begin
				peak_q <= pk_mag;
			end
		end
		// feed the peak tracker: a fresh reconstruction, or a header value
		if (upd_s1) begin
			pk_src_q <= recon;
		end else if (adv && uop.pk) begin
			pk_src_q <= prev_v;
		end
	end

	// alarm level from the peak reconstructed magnitude
	always_comb begin
		if (peak_q >= high_q) begin
			level = 2'd2;
		end else if (peak_q >= med_q) begin
			level = 2'd1;
		end else begin
			level = 2'd0;
		end
	end

	// Output register: each loading step after the first pushes the previously held byte; the
	// final step pushes the last one with the alarm level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && want_push) begin
			out_v_q <= 1'b1;
		end else if (!packet_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && want_push) begin
			if (uop.jmp == J_END) begin
				out_q <= '{packet_byte: hold_q, last_byte: 1'b1, alarm_level: level};
			end else begin
				out_q <= '{packet_byte: hold_q, last_byte: 1'b0, alarm_level: 2'd0};
			end
		end
	end

endmodule

FILE: verif/tdpe_packet_checker.sv
// Scoreboard for the triaxial DPCM packet encoder: predicts every packet byte and compares it.
`timescale 1ns / 100ps
module tdpe_packet_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	input  logic                           sample_stall,
	input  tdpe_pkg::sample_t              sample,
	input  logic                           packet_valid,
	input  logic                           packet_stall,
	input  tdpe_pkg::packet_t              packet,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [tdpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	output int                             mismatches,
	output int                             bytes_due,
	output int                             packets_done,
	output int                             bytes_checked
);

	import tdpe_pkg::*;

	localparam logic [1:0] LEVEL_QUIET  = 2'd0;
	localparam logic [1:0] LEVEL_MEDIUM = 2'd1;
	localparam logic [1:0] LEVEL_HIGH   = 2'd2;
	localparam int         STEP  = int'(QUANT_STEP);
	localparam int         LIMIT = int'(DELTA_LIMIT);

	logic [15:0] off_x, off_y, off_z;
	logic [15:0] thr_medium, thr_high;
	stored_t     held_samples [SAMPLES_PER_PACKET];
	int          held;
	logic [15:0] seq_no;
	packet_t     bytes_q [$];

	function automatic int magnitude(input logic [15:0] v);
		int s;
		s = int'($signed(v));
		return (s < 0) ? -s : s;
	endfunction

	// round half away from zero, then clip to +-127
	function automatic logic [7:0] quantize_delta(input logic [15:0] diff);
		int d;
		int q;
		d = int'($signed(diff));
		q = (d >= 0) ? (d + STEP / 2) / STEP : (d - STEP / 2) / STEP;
		if (q > LIMIT)
			q = LIMIT;
		if (q < -LIMIT)
			q = -LIMIT;
		return q[7:0];
	endfunction

	function automatic packet_t body_byte(input logic [7:0] b);
		return '{packet_byte: b, last_byte: 1'b0, alarm_level: LEVEL_QUIET};
	endfunction

	function automatic void emit_packet();
		packet_t     pkt [$];
		packet_t     tail;
		logic [15:0] recon [3];
		logic [15:0] target [3];
		logic [7:0]  q;
		int          peak;
		pkt.push_back(body_byte(seq_no[7:0]));
		pkt.push_back(body_byte(seq_no[15:8]));
		pkt.push_back(body_byte(PKT_FLAGS));
		pkt.push_back(body_byte(held[7:0]));
		pkt.push_back(body_byte(QUANT_STEP));
		recon[0] = held_samples[0].x;
		recon[1] = held_samples[0].y;
		recon[2] = held_samples[0].z;
		peak = 0;
		for (int a = 0; a < 3; a++) begin
			pkt.push_back(body_byte(recon[a][7:0]));
			pkt.push_back(body_byte(recon[a][15:8]));
			if (magnitude(recon[a]) > peak)
				peak = magnitude(recon[a]);
		end
		// closed loop: each delta is taken against the decoder's reconstruction
		for (int i = 1; i < held; i++) begin
			target[0] = held_samples[i].x;
			target[1] = held_samples[i].y;
			target[2] = held_samples[i].z;
			for (int a = 0; a < 3; a++) begin
				q = quantize_delta(target[a] - recon[a]);
				pkt.push_back(body_byte(q));
				recon[a] = recon[a] + 16'($signed(q) * STEP);
				if (magnitude(recon[a]) > peak)
					peak = magnitude(recon[a]);
			end
		end
		tail = pkt[pkt.size() - 1];
		tail.last_byte = 1'b1;
		tail.alarm_level = (peak >= int'(thr_high)) ? LEVEL_HIGH :
			(peak >= int'(thr_medium)) ? LEVEL_MEDIUM : LEVEL_QUIET;
		pkt[pkt.size() - 1] = tail;
		foreach (pkt[k])
			bytes_q.push_back(pkt[k]);
		held = 0;
		seq_no = seq_no + 16'd1;
		packets_done++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		packet_t want;
		if (!arst_n) begin
			off_x = '0;
			off_y = '0;
			off_z = '0;
			thr_medium = MEDIUM_RST;
			thr_high = HIGH_RST;
			held = 0;
			seq_no = '0;
			bytes_q.delete();
			mismatches = 0;
			packets_done = 0;
			bytes_checked = 0;
			bytes_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_OFFSET_X: off_x = cfg_data;
					CFG_OFFSET_Y: off_y = cfg_data;
					CFG_OFFSET_Z: off_z = cfg_data;
					CFG_MEDIUM:   thr_medium = cfg_data;
					CFG_HIGH:     thr_high = cfg_data;
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall) begin
				if (sample.opcode == OP_SAMPLE) begin
					if (held < SAMPLES_PER_PACKET) begin
						held_samples[held] = '{z: sample.accel_z - off_z,
							y: sample.accel_y - off_y, x: sample.accel_x - off_x};
						held++;
					end
					if (held >= SAMPLES_PER_PACKET)
						emit_packet();
				end else if (held > 0) begin
					emit_packet();
				end
			end
			if (packet_valid && !packet_stall) begin
				if (bytes_q.size() == 0) begin
					mismatches++;
					$display("%0t: packet byte expected none, got %02h last %b level %0d",
						$time, packet.packet_byte, packet.last_byte, packet.alarm_level);
				end else begin
					want = bytes_q.pop_front();
					bytes_checked++;
					if (packet.packet_byte !== want.packet_byte) begin
						mismatches++;
						$display("%0t: packet_byte expected %02h, got %02h",
							$time, want.packet_byte, packet.packet_byte);
					end
					if (packet.last_byte !== want.last_byte) begin
						mismatches++;
						$display("%0t: last_byte expected %b, got %b",
							$time, want.last_byte, packet.last_byte);
					end
					if (packet.alarm_level !== want.alarm_level) begin
						mismatches++;
						$display("%0t: alarm_level expected %0d, got %0d",
							$time, want.alarm_level, packet.alarm_level);
					end
				end
			end
			bytes_due <= bytes_q.size();
		end
	end

endmodule

FILE: verif/tb_triaxial_dpcm_packet_encoder.sv
// Testbench top for the triaxial DPCM packet encoder: stimulus, stall patterns and verdict.
`timescale 1ns / 100ps
module tb_triaxial_dpcm_packet_encoder;
	import tdpe_pkg::*;

	localparam int QUIET_LIMIT     = 5000;  // cycles without any beat before giving up
	localparam int HOLD_CYCLES     = 400;   // long output hold-off that backs the block up
	localparam int SETTLE_CYCLES   = 64;    // covers a full packet's sequencer and peak tail
	localparam int ITEMS_PER_PHASE = 142;

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_stall;
	sample_t              sample;
	logic                 packet_valid;
	logic                 packet_stall = 1'b0;
	packet_t              packet;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	int mismatches;
	int bytes_due;
	int packets_done;
	int bytes_checked;

	// idle percentages of the two sides, and the pending output hold-off
	int send_pct = 19;
	int recv_pct = 60;
	int hold_len = 0;
	int quiet_cycles = 0;
	int held_now = 0;
	int beats_sent = 0;
	int reg_writes = 0;

	triaxial_dpcm_packet_encoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.packet_valid (packet_valid),
		.packet_stall (packet_stall),
		.packet       (packet),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	tdpe_packet_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.packet_valid  (packet_valid),
		.packet_stall  (packet_stall),
		.packet        (packet),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.bytes_due     (bytes_due),
		.packets_done  (packets_done),
		.bytes_checked (bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: a pending hold-off wins; otherwise stall at random.
	always @(posedge clk) begin
		if (hold_len > 0) begin
			packet_stall <= 1'b1;
			hold_len <= hold_len - 1;
		end else begin
			packet_stall <= ($urandom_range(0, 99) < recv_pct);
		end
	end

	// Watchdog: any beat on any channel restarts the count.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (packet_valid && !packet_stall) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: %0d cycles without a beat", quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one input beat after a random gap and hold it until taken.
	// Valid stays high afterwards so back-to-back beats never toggle it.
	task automatic send_beat(input logic op, input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] z);
		while ($urandom_range(0, 99) < send_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= '{opcode: op, accel_x: x, accel_y: y, accel_z: z};
		do
			@(posedge clk);
		while (sample_stall);
		beats_sent++;
		if (op == OP_SAMPLE)
			held_now = (held_now + 1) % SAMPLES_PER_PACKET;
		else
			held_now = 0;
	endtask

	// Write one register; the caller drops valid after its last write.
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		reg_writes++;
	endtask

	task automatic load_config(input logic [15:0] ox, input logic [15:0] oy,
		input logic [15:0] oz, input logic [15:0] med, input logic [15:0] high_thr);
		write_reg(CFG_OFFSET_X, ox);
		write_reg(CFG_OFFSET_Y, oy);
		write_reg(CFG_OFFSET_Z, oz);
		write_reg(CFG_MEDIUM, med);
		write_reg(CFG_HIGH, high_thr);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every predicted byte, then let the sequencer run dry.
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (bytes_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly a random walk around the previous reading, with jumps and rails.
	function automatic logic [15:0] reading(input logic [15:0] prev);
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 13)
			return prev + 16'($urandom_range(0, 4095)) - 16'd2048;
		else if (pick < 16)
			return prev + 16'($urandom_range(0, 65535)) - 16'd32768;
		else if (pick < 18)
			return 16'($urandom);
		else if (pick == 18)
			return 16'h8000;
		else
			return 16'h7FFF;
	endfunction

	task automatic random_phase(input int count);
		int          done_items;
		int          roll;
		logic [15:0] walk_x;
		logic [15:0] walk_y;
		logic [15:0] walk_z;
		done_items = 0;
		walk_x = 16'($urandom);
		walk_y = 16'($urandom);
		walk_z = 16'($urandom);
		while (done_items < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				// flush tick; payload is junk the block must ignore
				if (held_now != 0)
					done_items++;
				send_beat(OP_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				walk_x = reading(walk_x);
				walk_y = reading(walk_y);
				walk_z = reading(walk_z);
				send_beat(OP_SAMPLE, walk_x, walk_y, walk_z);
				done_items++;
			end
		end
		// drain whatever is still buffered before the settings change
		send_beat(OP_FLUSH, '0, '0, '0);
	endtask

	initial begin
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_OFFSET_X;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset settings: offsets 0, thresholds 200 / 800.
		// flush with nothing buffered: no packet
		send_beat(OP_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// one-sample packet at both rails
		send_beat(OP_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000);
		send_beat(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
		// rounding ties, saturation both ways, and a difference that wraps 16 bits
		send_beat(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
		send_beat(OP_SAMPLE, 16'd64, 16'hFFC0, 16'd63);
		send_beat(OP_SAMPLE, 16'h7FFF, 16'h8000, 16'hFFC1);
		send_beat(OP_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000);
		send_beat(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
		// peak just under the medium threshold: quiet
		send_beat(OP_SAMPLE, 16'd10, 16'hFFF6, 16'd199);
		send_beat(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
		// peak exactly on the medium threshold
		send_beat(OP_SAMPLE, 16'h0000, 16'hFF38, 16'h0000);
		send_beat(OP_FLUSH, 16'h0000, 16'h0000, 16'h0000);
		// full buffer goes out on the twelfth sample; the flush after finds nothing
		for (int i = 0; i < SAMPLES_PER_PACKET; i++)
			send_beat(OP_SAMPLE, 16'(i * 700), 16'(-i * 50), 16'(i * 3));
		send_beat(OP_FLUSH, 16'h5A5A, 16'hA5A5, 16'h5A5A);
		settle();

		// Phase one: sender idles lightly, receiver stalls often; random settings.
		load_config(16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom_range(0, 2000)), 16'($urandom_range(2000, 20000)));
		random_phase(ITEMS_PER_PHASE);
		settle();

		// Phase two: roles swapped; offsets at the rails and zero, thresholds at zero.
		send_pct = 60;
		recv_pct <= 19;
		load_config(16'h8000, 16'h7FFF, 16'h0000, 16'd0, 16'd0);
		random_phase(ITEMS_PER_PHASE);
		settle();

		// Phase three: no idling; thresholds at the top, long output hold first.
		send_pct = 0;
		recv_pct <= 0;
		load_config(16'h7FFF, 16'h8000, 16'hFFFF, 16'd32768, 16'd32768);
		hold_len <= HOLD_CYCLES;
		random_phase(ITEMS_PER_PHASE);
		settle();

		$display("Run covered %0d input beats and %0d register writes over four settings,",
			beats_sent, reg_writes);
		$display("with %0d packets (%0d bytes) checked against prediction.",
			packets_done, bytes_checked);
		if (mismatches == 0 && bytes_due == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/tdpe_pkg.sv
hw/rtl/tdpe_ram.sv
hw/rtl/triaxial_dpcm_packet_encoder.sv
verif/tdpe_packet_checker.sv
verif/tb_triaxial_dpcm_packet_encoder.sv
